// ===== sv/grd_pkg.sv =====
`timescale 1ns / 1ps
package grd_pkg;

	localparam int MAP_ROWS_MAX = 64;
	localparam int MAP_COLS_MAX = 64;
	localparam int FRAC_BITS    = 16;
	localparam int ROW_W        = $clog2(MAP_ROWS_MAX);
	localparam int COL_W        = $clog2(MAP_COLS_MAX);
	localparam int ADDR_W       = ROW_W + COL_W;
	localparam int DIST_W       = 24;
	localparam int RAY_W        = 20;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	// divider operand widths: numerator holds 2^(2*FRAC_BITS), denominator |ray|
	localparam int NUM_W = 2 * FRAC_BITS + 1;
	localparam int DEN_W = RAY_W;

	// register indexes
	localparam logic [2:0] REG_POS_X    = 3'd0;
	localparam logic [2:0] REG_POS_Y    = 3'd1;
	localparam logic [2:0] REG_DIR_X    = 3'd2;
	localparam logic [2:0] REG_DIR_Y    = 3'd3;
	localparam logic [2:0] REG_PLANE_X  = 3'd4;
	localparam logic [2:0] REG_PLANE_Y  = 3'd5;
	localparam logic [2:0] REG_SCREEN_W = 3'd6;
	localparam logic [2:0] REG_MAP_ROWS = 3'd7;

	// operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	typedef struct packed {
		logic [21:0]        pos_x;
		logic [21:0]        pos_y;
		logic signed [18:0] dir_x;
		logic signed [18:0] dir_y;
		logic signed [18:0] plane_x;
		logic signed [18:0] plane_y;
		logic [12:0]        screen_width;
		logic [6:0]         map_rows;
	} cfg_t;

	typedef struct packed {
		logic        op;
		logic [11:0] ray_column;
		logic [5:0]  cell_row;
		logic [5:0]  cell_col;
		logic        cell_wall;
	} item_t;

	// queue handshake between front and back
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_out_t;

	typedef struct packed {
		logic pop;
		logic clearing;
	} q_ctl_t;

	typedef struct packed {
		logic                     hit;
		logic                     side;
		logic [5:0]               hit_col;
		logic [5:0]               hit_row;
		logic signed [1:0]        step_col;
		logic signed [1:0]        step_row;
		logic [DIST_W-1:0]        side_dist_col;
		logic [DIST_W-1:0]        side_dist_row;
		logic [DIST_W-1:0]        delta_col;
		logic [DIST_W-1:0]        delta_row;
		logic signed [RAY_W-1:0]  ray_x;
		logic signed [RAY_W-1:0]  ray_y;
	} res_t;

endpackage

// ===== sv/grd_front.sv =====
`timescale 1ns / 1ps
module grd_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  grd_pkg::item_t  s_item,
	output grd_pkg::q_out_t q_out,
	input  grd_pkg::q_ctl_t q_ctl
);
	import grd_pkg::*;

	item_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	// accept while the queue has room and the map is not being cleared
	assign s_tready = (count_q != 2'd2) && !q_ctl.clearing;
	assign push     = s_tvalid && s_tready;

	assign q_out.valid = (count_q != 2'd0);
	assign q_out.item  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= s_item;
		end
	end

	// two-entry queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (q_ctl.pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, q_ctl.pop};
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_ctl.pop |-> count_q != 2'd0) else $error("pop from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue overflow");
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		q_ctl.clearing |-> !push) else $error("transfer during map clear");

endmodule

// ===== sv/grd_div.sv =====
`timescale 1ns / 1ps
module grd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [grd_pkg::NUM_W-1:0]   num,
	input  logic [grd_pkg::DEN_W-1:0]   den,
	output logic                        done,
	output logic [grd_pkg::NUM_W-1:0]   quo
);
	import grd_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic             qbit;
	logic [DEN_W:0]   rem_sub;

	// one restoring step: shift in the next numerator bit, subtract if it fits
	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign qbit    = (rem_sh >= {1'b0, den_q});
	assign rem_sub = qbit ? (rem_sh - {1'b0, den_q}) : rem_sh;

	assign done = done_q;
	assign quo  = num_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= rem_sub[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(NUM_W);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// ===== sv/grd_back.sv =====
`timescale 1ns / 1ps
module grd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  grd_pkg::cfg_t   cfg,
	input  grd_pkg::q_out_t q_out,
	output grd_pkg::q_ctl_t q_ctl,
	output logic            res_valid,
	input  logic            res_ready,
	output grd_pkg::res_t   res
);
	import grd_pkg::*;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_CAM_GO, ST_CAM_W, ST_MUL_X, ST_MUL_Y, ST_ADD_Y,
		ST_RCX_GO, ST_RCX_W, ST_RCY_GO, ST_RCY_W, ST_SD_X, ST_SD_Y, ST_SD_E,
		ST_WALK, ST_TEST_A, ST_TEST_B, ST_DONE
	} state_t;

	localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [51:0] RMAX = 52'sd524287;
	localparam logic signed [51:0] RMIN = -52'sd524288;

	state_t                  state_q;
	logic [ADDR_W-1:0]       clr_q;
	item_t                   item_q;
	logic                    mem [MAP_ROWS_MAX*MAP_COLS_MAX];
	logic                    rd_q;
	logic signed [31:0]      cam_q;
	logic signed [50:0]      prod_q;
	logic signed [RAY_W-1:0] rx_q, ry_q;
	logic [DIST_W-1:0]       dcx_q, dcy_q, sx_q, sy_q;
	logic [40:0]             mp_q;
	logic signed [7:0]       mc_q, mr_q;
	logic                    side_q, hit_q;
	logic                    ovalid_q;
	res_t                    res_q;

	logic                    div_start;
	logic [NUM_W-1:0]        div_num;
	logic [DEN_W-1:0]        div_den;
	logic                    div_done;
	logic [NUM_W-1:0]        div_quo;
	logic                    out_free;
	logic [12:0]             width_eff;
	logic [6:0]              rows_eff;
	logic [RAY_W-1:0]        abs_rx, abs_ry;
	logic [16:0]             tx, ty;
	logic signed [51:0]      ray_sum;
	logic signed [RAY_W-1:0] ray_sat;
	logic [DIST_W:0]         sx_add, sy_add;
	logic [DIST_W-1:0]       sd_sat;
	logic [DIST_W-1:0]       rcp_sat;
	logic                    out_map;

	grd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign width_eff = (cfg.screen_width == 13'd0) ? 13'd1 : cfg.screen_width;
	assign rows_eff  = (cfg.map_rows > 7'(MAP_ROWS_MAX)) ? 7'(MAP_ROWS_MAX) : cfg.map_rows;
	assign abs_rx    = rx_q[RAY_W-1] ? RAY_W'(-rx_q) : RAY_W'(rx_q);
	assign abs_ry    = ry_q[RAY_W-1] ? RAY_W'(-ry_q) : RAY_W'(ry_q);
	assign tx = rx_q[RAY_W-1] ? {1'b0, cfg.pos_x[15:0]} : 17'h10000 - {1'b0, cfg.pos_x[15:0]};
	assign ty = ry_q[RAY_W-1] ? {1'b0, cfg.pos_y[15:0]} : 17'h10000 - {1'b0, cfg.pos_y[15:0]};

	// ray component from the registered plane*cam product, clamped to 20 bits
	always_comb begin
		if (state_q == ST_MUL_Y)
			ray_sum = 52'(cfg.dir_x) + 52'(prod_q >>> FRAC_BITS);
		else
			ray_sum = 52'(cfg.dir_y) + 52'(prod_q >>> FRAC_BITS);
		if (ray_sum > RMAX)      ray_sat = RAY_W'(RMAX);
		else if (ray_sum < RMIN) ray_sat = RAY_W'(RMIN);
		else                     ray_sat = ray_sum[RAY_W-1:0];
	end

	assign rcp_sat = (div_quo > NUM_W'(DIST_MAX)) ? DIST_MAX : div_quo[DIST_W-1:0];
	assign sd_sat  = (mp_q[40:FRAC_BITS] > 25'(DIST_MAX)) ? DIST_MAX
		: mp_q[FRAC_BITS+DIST_W-1:FRAC_BITS];
	assign sx_add  = {1'b0, sx_q} + {1'b0, dcx_q};
	assign sy_add  = {1'b0, sy_q} + {1'b0, dcy_q};
	assign out_map = mc_q[7] || (mc_q >= 8'sd64) || mr_q[7] || (mr_q >= $signed({1'b0, rows_eff}));

	// divider operands for the three quotients
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (state_q)
			ST_CAM_GO: begin
				div_start = 1'b1;
				div_num   = NUM_W'({item_q.ray_column, 1'b0}) << FRAC_BITS;
				div_den   = DEN_W'(width_eff);
			end
			ST_RCX_GO: begin
				div_start = (rx_q != '0);
				div_num   = NUM_W'(1) << (2 * FRAC_BITS);
				div_den   = abs_rx;
			end
			ST_RCY_GO: begin
				div_start = (ry_q != '0);
				div_num   = NUM_W'(1) << (2 * FRAC_BITS);
				div_den   = abs_ry;
			end
			default: begin
			end
		endcase
	end

	assign out_free  = !ovalid_q || res_ready;
	assign q_ctl.pop = (state_q == ST_IDLE) && q_out.valid;
	assign q_ctl.clearing = (state_q == ST_CLEAR);
	assign res_valid = ovalid_q;
	assign res       = res_q;

	// wall map: clearing sweep, cell writes and registered walk reads
	always_ff @(posedge clk) begin
		if (state_q == ST_CLEAR)
			mem[clr_q] <= 1'b0;
		else if (q_ctl.pop && q_out.item.op == OP_WRITE)
			mem[{q_out.item.cell_row, q_out.item.cell_col}] <= q_out.item.cell_wall;
		if (state_q == ST_TEST_A)
			rd_q <= mem[{mr_q[ROW_W-1:0], mc_q[COL_W-1:0]}];
	end

	// sequencer with its registered datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			ovalid_q <= 1'b0;
			mc_q     <= '0;
			mr_q     <= '0;
			sx_q     <= '0;
			sy_q     <= '0;
		end else begin
			// output register: loaded on completion, emptied by a result transfer
			if (state_q == ST_DONE && out_free) ovalid_q <= 1'b1;
			else if (res_ready) ovalid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_out.valid) begin
						item_q  <= q_out.item;
						hit_q   <= 1'b0;
						side_q  <= 1'b0;
						state_q <= (q_out.item.op == OP_CAST) ? ST_CAM_GO : ST_DONE;
					end
				end
				ST_CAM_GO: state_q <= ST_CAM_W;
				ST_CAM_W: begin
					if (div_done) begin
						cam_q   <= $signed({3'b0, div_quo[28:0]}) - ONE;
						state_q <= ST_MUL_X;
					end
				end
				ST_MUL_X: begin
					prod_q  <= 51'(cfg.plane_x * cam_q);
					state_q <= ST_MUL_Y;
				end
				ST_MUL_Y: begin
					rx_q    <= ray_sat;
					prod_q  <= 51'(cfg.plane_y * cam_q);
					state_q <= ST_ADD_Y;
				end
				ST_ADD_Y: begin
					ry_q    <= ray_sat;
					state_q <= ST_RCX_GO;
				end
				ST_RCX_GO: begin
					if (rx_q == '0) begin
						dcx_q   <= DIST_MAX;
						state_q <= ST_RCY_GO;
					end else begin
						state_q <= ST_RCX_W;
					end
				end
				ST_RCX_W: begin
					if (div_done) begin
						dcx_q   <= rcp_sat;
						state_q <= ST_RCY_GO;
					end
				end
				ST_RCY_GO: begin
					if (ry_q == '0) begin
						dcy_q   <= DIST_MAX;
						state_q <= ST_SD_X;
					end else begin
						state_q <= ST_RCY_W;
					end
				end
				ST_RCY_W: begin
					if (div_done) begin
						dcy_q   <= rcp_sat;
						state_q <= ST_SD_X;
					end
				end
				ST_SD_X: begin
					mp_q    <= 41'(tx * dcx_q);
					mc_q    <= $signed({2'b0, cfg.pos_x[21:16]});
					mr_q    <= $signed({2'b0, cfg.pos_y[21:16]});
					state_q <= ST_SD_Y;
				end
				ST_SD_Y: begin
					sx_q    <= sd_sat;
					mp_q    <= 41'(ty * dcy_q);
					state_q <= ST_SD_E;
				end
				ST_SD_E: begin
					sy_q    <= sd_sat;
					state_q <= ST_WALK;
				end
				// one DDA step along the nearer side
				ST_WALK: begin
					if (sx_q < sy_q) begin
						sx_q   <= sx_add[DIST_W] ? DIST_MAX : sx_add[DIST_W-1:0];
						mc_q   <= rx_q[RAY_W-1] ? mc_q - 8'sd1 : mc_q + 8'sd1;
						side_q <= 1'b0;
					end else begin
						sy_q   <= sy_add[DIST_W] ? DIST_MAX : sy_add[DIST_W-1:0];
						mr_q   <= ry_q[RAY_W-1] ? mr_q - 8'sd1 : mr_q + 8'sd1;
						side_q <= 1'b1;
					end
					state_q <= ST_TEST_A;
				end
				ST_TEST_A: state_q <= out_map ? ST_DONE : ST_TEST_B;
				ST_TEST_B: begin
					if (rd_q) begin
						hit_q   <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						if (item_q.op == OP_WRITE) begin
							res_q <= '0;
						end else begin
							res_q.hit           <= hit_q;
							res_q.side          <= side_q;
							res_q.hit_col       <= hit_q ? mc_q[5:0] : 6'd0;
							res_q.hit_row       <= hit_q ? mr_q[5:0] : 6'd0;
							res_q.step_col      <= rx_q[RAY_W-1] ? -2'sd1 : 2'sd1;
							res_q.step_row      <= ry_q[RAY_W-1] ? -2'sd1 : 2'sd1;
							res_q.side_dist_col <= sx_q;
							res_q.side_dist_row <= sy_q;
							res_q.delta_col     <= dcx_q;
							res_q.delta_row     <= dcy_q;
							res_q.ray_x         <= rx_q;
							res_q.ray_y         <= ry_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && !res_ready |=> ovalid_q && $stable(res_q))
		else $error("result overwritten while waiting");
	a_read_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TEST_B |-> !mc_q[7] && !mr_q[7] && mc_q < 8'sd64 && mr_q < 8'sd64)
		else $error("map read outside the array");
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !q_ctl.pop) else $error("item taken during clear");

endmodule

// ===== sv/grid_raycast_dda.sv =====
`timescale 1ns / 1ps
// DDA ray caster over a 64 x 64 wall map. After reset all 4096 map cells are
// cleared in a sweep during which no item is taken. A cast runs one
// bit-serial divider up to three times (camera coordinate, then the two
// reciprocals, each skipped for a zero ray component), multiplies for the ray
// and the side distances, then walks the grid; each step passes through the
// walk state and two map test states. A two-entry queue at the input and an
// output register let the caller stream items while a cast is running.
module grid_raycast_dda (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [31:0]  s_tdata,  // ray_column[11:0], cell_row[17:12], cell_col[23:18],
	                               // cell_wall[24], zero fill
	input  logic         s_tuser,  // op
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [159:0] m_tdata,  // side, hit_col, hit_row, step_col, step_row,
	                               // side_dist_col, side_dist_row, delta_col, delta_row,
	                               // ray_x, ray_y, zero fill
	output logic         m_tuser,  // hit
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [21:0]  cfg_data
);
	import grd_pkg::*;

	cfg_t    cfg_q;
	item_t   s_item;
	q_out_t  q_out;
	q_ctl_t  q_ctl;
	res_t    res;

	assign s_item.op         = s_tuser;
	assign s_item.ray_column = s_tdata[11:0];
	assign s_item.cell_row   = s_tdata[17:12];
	assign s_item.cell_col   = s_tdata[23:18];
	assign s_item.cell_wall  = s_tdata[24];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_x        <= '0;
			cfg_q.pos_y        <= '0;
			cfg_q.dir_x        <= 19'sd65536;
			cfg_q.dir_y        <= '0;
			cfg_q.plane_x      <= '0;
			cfg_q.plane_y      <= 19'sd43254;
			cfg_q.screen_width <= 13'd640;
			cfg_q.map_rows     <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_POS_X:    cfg_q.pos_x        <= cfg_data;
				REG_POS_Y:    cfg_q.pos_y        <= cfg_data;
				REG_DIR_X:    cfg_q.dir_x        <= $signed(cfg_data[18:0]);
				REG_DIR_Y:    cfg_q.dir_y        <= $signed(cfg_data[18:0]);
				REG_PLANE_X:  cfg_q.plane_x      <= $signed(cfg_data[18:0]);
				REG_PLANE_Y:  cfg_q.plane_y      <= $signed(cfg_data[18:0]);
				REG_SCREEN_W: cfg_q.screen_width <= cfg_data[12:0];
				REG_MAP_ROWS: cfg_q.map_rows     <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	grd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_item   (s_item),
		.q_out    (q_out),
		.q_ctl    (q_ctl)
	);

	grd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_out     (q_out),
		.q_ctl     (q_ctl),
		.res_valid (m_tvalid),
		.res_ready (m_tready),
		.res       (res)
	);

	assign m_tuser = res.hit;
	assign m_tdata = {7'd0, res.ray_y, res.ray_x, res.delta_row, res.delta_col,
		res.side_dist_row, res.side_dist_col, res.step_row, res.step_col,
		res.hit_row, res.hit_col, res.side};

endmodule
